/* hdl/min_tracking_stack_defines.svh */
// assertion macros for the min tracking stack checker
// no dependencies
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// same-cycle implication
`define MST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("min tracking stack check failed");

// next-cycle implication
`define MST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("min tracking stack check failed");

`endif

/* hdl/mst_pkg.sv */
// shared types and constants of the min tracking stack
// no dependencies
`default_nettype none

package mst_pkg;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;

   localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_READ
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_REFILL
   } state_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic signed [31:0] min_value;
      logic               is_empty;
      logic               is_full;
      logic               op_error;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/mst_front.sv */
// front end: accepts request words, decodes the mode and buffers them
// depends on mst_pkg
`default_nettype none

module mst_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [31:0] req_push_value,
   output logic                    req_full,
   output logic                    cmd_valid,
   output mst_pkg::cmd_type        cmd_word,
   input  wire logic               cmd_take
);

   mst_pkg::cmd_type q_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_wr;
   logic             do_rd;
   mst_pkg::cmd_type decoded;

   always_comb begin
      decoded.value = req_push_value;
      case (req_mode)
         mst_pkg::MODE_PUSH: decoded.op = mst_pkg::OP_PUSH;
         mst_pkg::MODE_POP:  decoded.op = mst_pkg::OP_POP;
         default:            decoded.op = mst_pkg::OP_READ;
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_word  = q_ff[rd_ff];
   assign do_wr     = req_push && !req_full;
   assign do_rd     = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = do_wr ? !wr_ff : wr_ff;
      rd_in  = do_rd ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

/* hdl/mst_exec.sv */
// back end: value and minimum stacks with cached tops, one command at a time
// depends on mst_pkg
`default_nettype none

module mst_exec #(
   parameter int DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  mst_pkg::cmd_type       cmd_word,
   output logic                   cmd_take,
   input  wire logic              rsp_room,
   output logic                   rsp_write,
   output mst_pkg::rsp_type       rsp_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic signed [31:0] value_mem [DEPTH];
   logic signed [31:0] min_mem [DEPTH];

   mst_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      vc_ff, vc_in;
   logic [CW-1:0]      mc_ff, mc_in;
   logic signed [31:0] top_ff, top_in;
   logic signed [31:0] min_ff, min_in;
   logic               pop_min_ff, pop_min_in;
   logic signed [31:0] vrd_ff, mrd_ff;

   logic               v_we, m_we, rd_en;
   logic [CW-1:0]      vc_prev2, mc_prev2;
   logic [CW-1:0]      vc_next, mc_next;

   assign vc_prev2 = vc_ff - CW'(2);
   assign mc_prev2 = mc_ff - CW'(2);
   assign vc_next  = vc_ff + CW'(1);
   assign mc_next  = mc_ff + CW'(1);

   always_comb begin
      state_in   = state_ff;
      vc_in      = vc_ff;
      mc_in      = mc_ff;
      top_in     = top_ff;
      min_in     = min_ff;
      pop_min_in = pop_min_ff;
      v_we       = 1'b0;
      m_we       = 1'b0;
      rd_en      = 1'b0;
      cmd_take   = 1'b0;
      rsp_write  = 1'b0;
      rsp_word.op_error = 1'b0;

      case (state_ff)
         mst_pkg::ST_IDLE: begin
            if (cmd_valid && rsp_room) begin
               cmd_take = 1'b1;
               case (cmd_word.op)
                  mst_pkg::OP_PUSH: begin
                     rsp_write = 1'b1;
                     if (vc_ff == FULL_COUNT) begin
                        rsp_word.op_error = 1'b1;
                     end else begin
                        v_we   = 1'b1;
                        vc_in  = vc_next;
                        top_in = cmd_word.value;
                        if (mc_ff == '0 || cmd_word.value <= min_ff) begin
                           m_we   = 1'b1;
                           mc_in  = mc_next;
                           min_in = cmd_word.value;
                        end
                     end
                  end
                  mst_pkg::OP_POP: begin
                     if (vc_ff == '0) begin
                        rsp_write         = 1'b1;
                        rsp_word.op_error = 1'b1;
                     end else begin
                        rd_en      = 1'b1;
                        pop_min_in = (top_ff <= min_ff);
                        vc_in      = vc_ff - CW'(1);
                        mc_in      = (top_ff <= min_ff) ? mc_ff - CW'(1) : mc_ff;
                        state_in   = mst_pkg::ST_REFILL;
                     end
                  end
                  default: begin
                     rsp_write = 1'b1;
                  end
               endcase
            end
         end
         mst_pkg::ST_REFILL: begin
            rsp_write = 1'b1;
            state_in  = mst_pkg::ST_IDLE;
            top_in    = (vc_ff == '0) ? 32'sd0 : vrd_ff;
            if (pop_min_ff) begin
               min_in = (mc_ff == '0) ? mst_pkg::EMPTY_MIN : mrd_ff;
            end
         end
         default: begin
            state_in = mst_pkg::ST_IDLE;
         end
      endcase

      rsp_word.top_value = top_in;
      rsp_word.min_value = min_in;
      rsp_word.is_empty  = (vc_in == '0);
      rsp_word.is_full   = (vc_in == FULL_COUNT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mst_pkg::ST_IDLE;
         vc_ff      <= '0;
         mc_ff      <= '0;
         top_ff     <= 32'sd0;
         min_ff     <= mst_pkg::EMPTY_MIN;
         pop_min_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vc_ff      <= vc_in;
         mc_ff      <= mc_in;
         top_ff     <= top_in;
         min_ff     <= min_in;
         pop_min_ff <= pop_min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         value_mem[vc_ff[AW-1:0]] <= cmd_word.value;
      end
      if (rd_en) begin
         vrd_ff <= value_mem[vc_prev2[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (m_we) begin
         min_mem[mc_ff[AW-1:0]] <= cmd_word.value;
      end
      if (rd_en) begin
         mrd_ff <= min_mem[mc_prev2[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

/* hdl/mst_rsp_queue.sv */
// two-word result queue in front of the response ports
// depends on mst_pkg
`default_nettype none

module mst_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rsp_write,
   input  mst_pkg::rsp_type       rsp_word,
   output logic                   rsp_room,
   output logic                   rsp_empty,
   output mst_pkg::rsp_type       head_word,
   input  wire logic              rsp_pop
);

   mst_pkg::rsp_type q_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_wr;
   logic             do_rd;

   assign rsp_room  = (cnt_ff != 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign head_word = q_ff[rd_ff];
   assign do_wr     = rsp_write && rsp_room;
   assign do_rd     = rsp_pop && !rsp_empty;

   always_comb begin
      wr_in  = do_wr ? !wr_ff : wr_ff;
      rd_in  = do_rd ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ff] <= rsp_word;
      end
   end

endmodule

`default_nettype wire

/* hdl/min_tracking_stack.sv */
// min tracking stack: LIFO of signed 32-bit words that also reports its minimum
// depends on mst_pkg, mst_front, mst_exec, mst_rsp_queue
//
// request side: push a word (req_mode, req_push_value) while req_full is low;
// mode 0 pushes, 1 pops, anything else only reads. every request word gives
// exactly one response word: top and minimum after the operation, empty and
// full flags, and op_error when a pop on empty or push on full was refused.
// response side: while rsp_empty is low the oldest response is on the rsp_
// ports; raise rsp_pop to take it.
// a two-word request queue decouples decoding from execution. push and read
// complete in the idle state of the back end; pop goes on to a refill state,
// as the new top comes back from the registered stack memory read. sustained
// rate is one word a cycle for push and read while the response queue has
// room; the back end takes no new request while a pop refills.
// when rsp_pop stays low the two-word response queue fills, the back end
// stops, and then the request queue fills and req_full rises.
// reset empties the stack and both queues at once; no clearing pass.
`default_nettype none

module min_tracking_stack #(
   parameter int DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [31:0] req_push_value,
   output logic                    req_full,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [31:0]      rsp_top_value,
   output logic signed [31:0]      rsp_min_value,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full,
   output logic                    rsp_op_error
);

   logic             cmd_valid;
   logic             cmd_take;
   mst_pkg::cmd_type cmd_word;
   logic             rsp_room;
   logic             rsp_write;
   mst_pkg::rsp_type rsp_word;
   mst_pkg::rsp_type head_word;

   mst_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .req_full       (req_full),
      .cmd_valid      (cmd_valid),
      .cmd_word       (cmd_word),
      .cmd_take       (cmd_take)
   );

   mst_exec #(
      .DEPTH (DEPTH)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_take  (cmd_take),
      .rsp_room  (rsp_room),
      .rsp_write (rsp_write),
      .rsp_word  (rsp_word)
   );

   mst_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_write (rsp_write),
      .rsp_word  (rsp_word),
      .rsp_room  (rsp_room),
      .rsp_empty (rsp_empty),
      .head_word (head_word),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_top_value = head_word.top_value;
   assign rsp_min_value = head_word.min_value;
   assign rsp_is_empty  = head_word.is_empty;
   assign rsp_is_full   = head_word.is_full;
   assign rsp_op_error  = head_word.op_error;

endmodule

`default_nettype wire

/* hdl/mst_checker.sv */
// port-level checks of the min tracking stack, bound to the top level
// depends on min_tracking_stack_defines.svh and min_tracking_stack
`default_nettype none
`include "min_tracking_stack_defines.svh"

module mst_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic signed [31:0] rsp_top_value,
   input wire logic signed [31:0] rsp_min_value,
   input wire logic               rsp_is_empty,
   input wire logic               rsp_is_full
);

   // an empty stack reports the fixed top and minimum
   `MST_ASSERT_NOW(a_empty_word, clock, reset, !rsp_empty && rsp_is_empty, rsp_top_value == 32'sd0 && rsp_min_value == 32'sh7FFF_FFFF)

   // full and empty never together
   `MST_ASSERT_NOW(a_full_not_empty, clock, reset, !rsp_empty && rsp_is_full, !rsp_is_empty)

   // the minimum of held words never exceeds the top
   `MST_ASSERT_NOW(a_min_le_top, clock, reset, !rsp_empty && !rsp_is_empty, rsp_min_value <= rsp_top_value)

   // a waiting response word holds until taken
   `MST_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_top_value) && $stable(rsp_min_value))

endmodule

bind min_tracking_stack mst_checker u_mst_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_top_value (rsp_top_value),
   .rsp_min_value (rsp_min_value),
   .rsp_is_empty  (rsp_is_empty),
   .rsp_is_full   (rsp_is_full)
);

`default_nettype wire

/* tb/sv/min_tracking_stack_test.sv */
// self-checking testbench of min_tracking_stack: push, pop and read words with random gaps
// predicts every response word from its own copy of both stacks; depends on mst_pkg
`timescale 1ns / 100ps

module min_tracking_stack_test;

   localparam int DEPTH         = 64;
   localparam int ITEM_TARGET   = 1050;
   localparam int IDLE_PERCENT  = 31;
   localparam int CALM_FROM     = 800;
   localparam int CALM_UNTIL    = 1400;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;

   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
      logic               wait_drain;
   } stack_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic [1:0]         req_mode = MODE_SPARE;
   logic signed [31:0] req_push_value = '0;
   logic               req_full;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [31:0] rsp_top_value;
   logic signed [31:0] rsp_min_value;
   logic               rsp_is_empty;
   logic               rsp_is_full;
   logic               rsp_op_error;

   stack_request_type pending_words[$];
   mst_pkg::rsp_type  expected_words[$];

   logic signed [31:0] held_words[DEPTH];
   logic signed [31:0] min_words[DEPTH];
   int                 held_count = 0;
   int                 min_count = 0;

   int planned_depth = 0;
   int queued_words = 0;
   int sent_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_cycles = 0;

   wire calm = cycle_count >= CALM_FROM && cycle_count < CALM_UNTIL;

   min_tracking_stack #(
      .DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_mode(req_mode),
      .req_push_value(req_push_value),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_top_value(rsp_top_value),
      .rsp_min_value(rsp_min_value),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full),
      .rsp_op_error(rsp_op_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mst_pkg::rsp_type apply_stack_op(input logic [1:0] mode,
                                                       input logic signed [31:0] value);
      mst_pkg::rsp_type outcome;
      outcome.op_error = 1'b0;
      case (mode)
         mst_pkg::OP_PUSH: begin
            if (held_count >= DEPTH) begin
               outcome.op_error = 1'b1;
            end else begin
               held_words[held_count] = value;
               held_count++;
               if (min_count == 0 || value <= min_words[min_count - 1]) begin
                  min_words[min_count] = value;
                  min_count++;
               end
            end
         end
         mst_pkg::OP_POP: begin
            if (held_count == 0) begin
               outcome.op_error = 1'b1;
            end else begin
               if (min_count > 0 && held_words[held_count - 1] <= min_words[min_count - 1])
                  min_count--;
               held_count--;
            end
         end
         default: ;
      endcase
      outcome.top_value = held_count > 0 ? held_words[held_count - 1] : 32'sd0;
      outcome.min_value = (held_count > 0 && min_count > 0) ? min_words[min_count - 1]
                                                             : mst_pkg::EMPTY_MIN;
      outcome.is_empty = held_count == 0;
      outcome.is_full = held_count >= DEPTH;
      return outcome;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 20)) - 32'sd10;
         7: return 32'sh7FFF_FFFF;
         8: return 32'sh8000_0000;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic queue_word(input logic [1:0] mode, input logic signed [31:0] value,
                             input logic wait_drain);
      stack_request_type word;
      word.mode = mode;
      word.value = value;
      word.wait_drain = wait_drain;
      pending_words.push_back(word);
      queued_words++;
      if (mode == mst_pkg::OP_PUSH && planned_depth < DEPTH)
         planned_depth++;
      else if (mode == mst_pkg::OP_POP && planned_depth > 0)
         planned_depth--;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, name, $signed(want), $signed(got));
         mismatch_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      stack_request_type next_word;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_words.push_back(apply_stack_op(req_mode, req_push_value));
            sent_count++;
         end
         if (!req_push || !req_full) begin
            if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)
                && (!pending_words[0].wait_drain || sent_count == checked_count)) begin
               next_word = pending_words.pop_front();
               req_push <= 1'b1;
               req_mode <= next_word.mode;
               req_push_value <= next_word.value;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      mst_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               $display("%0t: response word with none expected, actual top %0d min %0d",
                        $time, rsp_top_value, rsp_min_value);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("top_value", want.top_value, rsp_top_value);
               check_field("min_value", want.min_value, rsp_min_value);
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
               check_field("is_full", 32'(want.is_full), 32'(rsp_is_full));
               check_field("op_error", 32'(want.op_error), 32'(rsp_op_error));
            end
            checked_count <= checked_count + 1;
         end
         rsp_pop <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int burst_len;
      int extra;
      bit descend;
      int base;
      int roll;

      // directed words
      queue_word(mst_pkg::OP_READ, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(MODE_SPARE, 32'sh7FFF_FFFF, 1'b0);
      queue_word(mst_pkg::OP_PUSH, 32'sh7FFF_FFFF, 1'b0);
      queue_word(mst_pkg::OP_PUSH, 32'sh8000_0000, 1'b0);
      queue_word(mst_pkg::OP_PUSH, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_PUSH, 32'sh8000_0000, 1'b0);
      queue_word(mst_pkg::OP_READ, 32'sh8000_0000, 1'b0);
      queue_word(MODE_SPARE, $signed($urandom), 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sh7FFF_FFFF, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_PUSH, -32'sd1, 1'b1);
      queue_word(mst_pkg::OP_PUSH, 32'sd5, 1'b0);
      queue_word(mst_pkg::OP_PUSH, -32'sd1, 1'b0);
      queue_word(mst_pkg::OP_PUSH, -32'sd3, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_POP, 32'sd0, 1'b0);
      queue_word(mst_pkg::OP_READ, 32'sd0, 1'b0);

      // random bursts: fill to full, drain to empty, or a random walk
      while (queued_words < ITEM_TARGET) begin
         roll = $urandom_range(0, 9);
         if (roll < 2) begin
            descend = 1'($urandom_range(0, 1));
            base = $urandom_range(0, 2000);
            queue_word(mst_pkg::OP_READ, $signed($urandom), $urandom_range(0, 3) == 0);
            while (planned_depth < DEPTH)
               queue_word(mst_pkg::OP_PUSH, descend ? base - planned_depth : pick_value(),
                          1'b0);
            extra = $urandom_range(1, 3);
            repeat (extra) queue_word(mst_pkg::OP_PUSH, pick_value(), 1'b0);
         end else if (roll < 4) begin
            while (planned_depth > 0)
               queue_word($urandom_range(0, 9) == 0 ? mst_pkg::OP_READ : mst_pkg::OP_POP,
                          $signed($urandom), 1'b0);
            extra = $urandom_range(1, 3);
            repeat (extra) queue_word(mst_pkg::OP_POP, $signed($urandom), 1'b0);
         end else begin
            burst_len = $urandom_range(20, 60);
            repeat (burst_len) begin
               roll = $urandom_range(0, 99);
               if (roll < 45)
                  queue_word(mst_pkg::OP_PUSH, pick_value(), 1'b0);
               else if (roll < 85)
                  queue_word(mst_pkg::OP_POP, $signed($urandom), 1'b0);
               else if (roll < 97)
                  queue_word(mst_pkg::OP_READ, $signed($urandom), 1'b0);
               else
                  queue_word(MODE_SPARE, $signed($urandom), 1'b0);
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_push) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
